// ===== src/priority_process_scheduler_assert.svh =====
// Assertion macros for the process scheduler
`ifndef PRIORITY_PROCESS_SCHEDULER_ASSERT_SVH
`define PRIORITY_PROCESS_SCHEDULER_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define PPS_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Implication checked in the cycle after the antecedent
`define PPS_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== src/pps_pkg.sv =====
// Shared types and constants for the process scheduler
`timescale 1ns / 1ps
package pps_pkg;
  localparam int unsigned NumSlotsDef = 16;
  localparam logic [7:0]  QuantumRst  = 8'd10;
  localparam logic [9:0]  TpsRst      = 10'd100;
  localparam logic [3:0]  PrioRst     = 4'd5;
  localparam logic [31:0] MemBaseRst  = 32'h0001_0000;
  localparam logic [31:0] KMemStart   = 32'h0000_1000;
  localparam logic [31:0] KMemSize    = 32'h0000_7000;
  localparam logic [3:0]  PrioWorst   = 4'd9;

  typedef enum logic [2:0] {
    K_TICK = 3'd0, K_CREATE = 3'd1, K_KILL = 3'd2, K_SLEEP = 3'd3,
    K_SETPRIO = 3'd4, K_QUERY = 3'd5, K_RSV6 = 3'd6, K_RSV7 = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_EMPTY = 3'd0, ST_RUNNING = 3'd1, ST_READY = 3'd2, ST_BLOCKED = 3'd3,
    ST_SLEEPING = 3'd4, ST_ZOMBIE = 3'd5
  } ent_st_t;

  localparam logic [2:0] RC_OK = 3'd0, RC_FULL = 3'd1, RC_NOENT = 3'd2,
                         RC_KERNEL = 3'd3, RC_BADPRIO = 3'd4;

  localparam logic [1:0] CFG_QUANTUM = 2'd0, CFG_TPS = 2'd1, CFG_PRIO = 2'd2,
                         CFG_BASE = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SWEEP, S_PICK, S_RESP
  } fsm_t;

  // Command from the sequencer to every cell
  typedef struct packed {
    logic        tick;     // count sleepers down, clear zombies
    logic        yield;    // running entry becomes ready
    logic        grant;    // winner becomes running
    logic        wr;       // write the addressed entry
    logic [5:0]  sel;      // addressed entry
    logic [2:0]  wr_st;
    logic        wr_prio;
    logic [3:0]  prio;
    logic        wr_sleep;
    logic [31:0] sleep;
    logic        init;     // create: load memory fields, clear counters
    logic [31:0] mstart;
    logic [31:0] msize;
  } cell_cmd_t;

  // Contents of one entry as read by the sequencer
  typedef struct packed {
    logic [2:0]  st;
    logic [3:0]  prio;
    logic [31:0] mstart;
    logic [31:0] msize;
    logic [31:0] quanta;
  } ent_t;
endpackage

// ===== src/pps_cell.sv =====
// One table entry with its link in the best-ready compare chain
`timescale 1ns / 1ps
module pps_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned SW  = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pps_pkg::cell_cmd_t cmd,
  input  logic [SW-1:0]    win,        // grant target
  input  logic             best_v_i,
  input  logic [3:0]       best_p_i,
  input  logic [SW-1:0]    best_s_i,
  output logic             best_v_o,
  output logic [3:0]       best_p_o,
  output logic [SW-1:0]    best_s_o,
  output pps_pkg::ent_t    ent
);
  localparam logic [SW-1:0] MyIdx = SW'(IDX);
  logic [2:0]  st_r;
  logic [3:0]  prio_r;
  logic [31:0] sleep_r, mstart_r, msize_r, quanta_r;
  logic        hit;

  assign hit = cmd.sel == 6'(IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= (IDX == 0) ? pps_pkg::ST_RUNNING : pps_pkg::ST_EMPTY;
      prio_r   <= (IDX == 0) ? 4'd1 : 4'd0;
      sleep_r  <= '0;
      mstart_r <= (IDX == 0) ? pps_pkg::KMemStart : 32'd0;
      msize_r  <= (IDX == 0) ? pps_pkg::KMemSize : 32'd0;
      quanta_r <= '0;
    end else begin
      if (cmd.tick) begin
        if (st_r == pps_pkg::ST_SLEEPING) begin
          if (sleep_r <= 32'd1) begin
            sleep_r <= '0;
            st_r    <= pps_pkg::ST_READY;
          end else begin
            sleep_r <= sleep_r - 32'd1;
          end
        end else if (st_r == pps_pkg::ST_ZOMBIE && IDX != 0) begin
          st_r <= pps_pkg::ST_EMPTY;
        end
      end
      if (cmd.yield && hit && st_r == pps_pkg::ST_RUNNING) st_r <= pps_pkg::ST_READY;
      if (cmd.grant && win == MyIdx) begin
        st_r     <= pps_pkg::ST_RUNNING;
        quanta_r <= quanta_r + 32'd1;
      end
      if (cmd.wr && hit) begin
        st_r <= cmd.wr_st;
        if (cmd.wr_prio)  prio_r  <= cmd.prio;
        if (cmd.wr_sleep) sleep_r <= cmd.sleep;
        if (cmd.init) begin
          sleep_r  <= '0;
          quanta_r <= '0;
          mstart_r <= cmd.mstart;
          msize_r  <= cmd.msize;
        end
      end
    end
  end

  // Registered link: the best so far moves one cell a cycle from slot 0 up.
  // Strict compare keeps the lower slot on a tie
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_v_o <= 1'b0;
      best_p_o <= '0;
      best_s_o <= '0;
    end else if (st_r == pps_pkg::ST_READY && (!best_v_i || prio_r < best_p_i)) begin
      best_v_o <= 1'b1;
      best_p_o <= prio_r;
      best_s_o <= MyIdx;
    end else begin
      best_v_o <= best_v_i;
      best_p_o <= best_p_i;
      best_s_o <= best_s_i;
    end
  end

  assign ent = '{st: st_r, prio: prio_r, mstart: mstart_r, msize: msize_r, quanta: quanta_r};
endmodule

// ===== src/priority_process_scheduler.sv =====
// Top level: sequencer, configuration registers and the row of entry cells
`timescale 1ns / 1ps
// Process table scheduler. Every transaction yields one result. A tick runs
// S_MUL for the sleep/zombie update, S_SWEEP for the yield and for the
// best-ready compare to ripple through a registered link in each cell, one
// cell a cycle, then S_PICK to grant and S_RESP to load the result. Every
// other kind runs S_MUL, S_PICK and S_RESP (the 32x10 sleep multiply is
// registered in S_MUL). The input is ready again in the cycle after the
// result is loaded; a result still waiting in the output register holds the
// next transaction in S_RESP.
`include "priority_process_scheduler_assert.svh"
module priority_process_scheduler #(
  parameter int unsigned NUM_SLOTS = pps_pkg::NumSlotsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // kind[2:0], slot[6:3], value[38:7], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], result_slot[6:3], current_slot_out[10:7], entry_state[13:11],
  // entry_priority[17:14], entry_memory_start[49:18], entry_memory_size[81:50],
  // entry_cpu_time[113:82], zero pad
  output logic [119:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned NW = $clog2(NUM_SLOTS + 1);

  pps_pkg::fsm_t st_r, st_nxt;
  logic [7:0]  quantum_r, phase_r;
  logic [9:0]  tps_r;
  logic [3:0]  dprio_r;
  logic [31:0] nbase_r;
  logic [NW-1:0] nnew_r;
  logic [SW-1:0] run_r;
  logic [2:0]  kind_r;
  logic [3:0]  slot_r;
  logic [31:0] val_r;
  logic [41:0] prod_r;
  logic [SW:0] cnt_r;
  logic        bv_r;
  logic [3:0]  bp_r;
  logic [SW-1:0] bs_r;
  logic        do_q_r;
  logic [2:0]  rc_r;
  logic [3:0]  rs_r;
  logic        show_r;
  logic        ov_r;
  logic [119:0] od_r;

  pps_pkg::cell_cmd_t cmd;
  pps_pkg::ent_t ents [NUM_SLOTS];
  logic          cv [NUM_SLOTS+1];
  logic [3:0]    cp [NUM_SLOTS+1];
  logic [SW-1:0] cs [NUM_SLOTS+1];

  assign cv[0] = 1'b0;
  assign cp[0] = '0;
  assign cs[0] = '0;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    pps_cell #(.IDX(g), .SW(SW)) u_cell (
      .clk, .rst_n, .cmd, .win(bs_r),
      .best_v_i(cv[g]), .best_p_i(cp[g]), .best_s_i(cs[g]),
      .best_v_o(cv[g+1]), .best_p_o(cp[g+1]), .best_s_o(cs[g+1]),
      .ent(ents[g])
    );
  end

  logic in_rng, exists;
  pps_pkg::ent_t tgt;
  logic [7:0] qeff, ph_inc;
  logic [119:0] resp;
  assign in_rng = 32'(slot_r) < NUM_SLOTS;
  assign tgt    = ents[SW'(slot_r)];
  assign exists = in_rng && tgt.st != pps_pkg::ST_EMPTY;
  assign qeff   = (quantum_r == 8'd0) ? 8'd1 : quantum_r;
  assign ph_inc = phase_r + 8'd1;

  assign in_tready = (st_r == pps_pkg::S_IDLE);
  assign cfg_ready = (st_r == pps_pkg::S_IDLE) && !in_tvalid;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  // Result word from the latched status and the addressed entry
  always_comb begin
    resp = '0;
    resp[2:0] = rc_r;
    resp[6:3] = rs_r;
    resp[10:7] = 4'(run_r);
    if (show_r && 32'(rs_r) < NUM_SLOTS) begin
      resp[13:11]  = ents[SW'(rs_r)].st;
      resp[17:14]  = ents[SW'(rs_r)].prio;
      resp[49:18]  = ents[SW'(rs_r)].mstart;
      resp[81:50]  = ents[SW'(rs_r)].msize;
      resp[113:82] = ents[SW'(rs_r)].quanta;
    end
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      pps_pkg::S_IDLE:  if (in_tvalid) st_nxt = pps_pkg::S_MUL;
      pps_pkg::S_MUL:   st_nxt = (kind_r == pps_pkg::K_TICK) ? pps_pkg::S_SWEEP :
                                 pps_pkg::S_PICK;
      pps_pkg::S_SWEEP: if (cnt_r == (SW+1)'(NUM_SLOTS + 1)) st_nxt = pps_pkg::S_PICK;
      pps_pkg::S_PICK:  st_nxt = pps_pkg::S_RESP;
      pps_pkg::S_RESP:  if (!ov_r || out_tready) st_nxt = pps_pkg::S_IDLE;
      default:          st_nxt = pps_pkg::S_IDLE;
    endcase
  end

  // Cell commands
  always_comb begin
    cmd = '0;
    cmd.sel = 6'(slot_r);
    cmd.prio = val_r[3:0];
    cmd.sleep = (prod_r[41:32] != '0) ? 32'hFFFF_FFFF : prod_r[31:0];
    cmd.mstart = nbase_r;
    cmd.msize = val_r;
    unique case (st_r)
      pps_pkg::S_MUL: begin
        if (kind_r == pps_pkg::K_TICK) cmd.tick = 1'b1;
      end
      pps_pkg::S_SWEEP: begin
        cmd.sel = 6'(run_r);
        cmd.yield = (cnt_r == '0) && do_q_r;
      end
      pps_pkg::S_PICK: begin
        unique case (kind_r)
          pps_pkg::K_TICK: cmd.grant = do_q_r && bv_r;
          pps_pkg::K_CREATE: begin
            cmd.sel = 6'(nnew_r);
            cmd.wr = 32'(nnew_r) < NUM_SLOTS;
            cmd.wr_st = pps_pkg::ST_READY;
            cmd.wr_prio = 1'b1;
            cmd.prio = (dprio_r > pps_pkg::PrioWorst) ? pps_pkg::PrioWorst : dprio_r;
            cmd.init = 1'b1;
          end
          pps_pkg::K_KILL: begin
            cmd.wr = exists && slot_r != 4'd0;
            cmd.wr_st = pps_pkg::ST_ZOMBIE;
          end
          pps_pkg::K_SLEEP: begin
            cmd.wr = exists && slot_r != 4'd0;
            cmd.wr_st = pps_pkg::ST_SLEEPING;
            cmd.wr_sleep = 1'b1;
          end
          pps_pkg::K_SETPRIO: begin
            cmd.wr = exists && val_r <= 32'(pps_pkg::PrioWorst);
            cmd.wr_st = tgt.st;
            cmd.wr_prio = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pps_pkg::S_IDLE;
      quantum_r <= pps_pkg::QuantumRst;
      tps_r <= pps_pkg::TpsRst;
      dprio_r <= pps_pkg::PrioRst;
      nbase_r <= pps_pkg::MemBaseRst;
      nnew_r <= NW'(1);
      run_r <= '0;
      phase_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_tready && st_r != pps_pkg::S_RESP) ov_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pps_pkg::CFG_QUANTUM: quantum_r <= cfg_data[7:0];
          pps_pkg::CFG_TPS:     tps_r <= cfg_data[9:0];
          pps_pkg::CFG_PRIO:    dprio_r <= cfg_data[3:0];
          pps_pkg::CFG_BASE: begin
            if (nnew_r == NW'(1)) nbase_r <= cfg_data;
          end
          default: ;
        endcase
      end
      unique case (st_r)
        pps_pkg::S_MUL: begin
          if (kind_r == pps_pkg::K_TICK) begin
            do_q_r <= ph_inc >= qeff;
            phase_r <= (ph_inc >= qeff) ? 8'd0 : ph_inc;
          end
        end
        pps_pkg::S_PICK: begin
          if (kind_r == pps_pkg::K_TICK && do_q_r && bv_r) run_r <= bs_r;
          if (kind_r == pps_pkg::K_CREATE && 32'(nnew_r) < NUM_SLOTS) begin
            nnew_r <= nnew_r + NW'(1);
            nbase_r <= nbase_r + val_r;
          end
        end
        pps_pkg::S_RESP: begin
          if (!ov_r || out_tready) begin
            ov_r <= 1'b1;
            od_r <= resp;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r <= in_tdata[2:0];
      slot_r <= in_tdata[6:3];
      val_r  <= in_tdata[38:7];
    end
    if (st_r == pps_pkg::S_MUL) begin
      prod_r <= val_r * {22'd0, tps_r};
      cnt_r <= '0;
    end
    if (st_r == pps_pkg::S_SWEEP) begin
      cnt_r <= cnt_r + (SW+1)'(1);
      // the chain settles after the yield; the value sampled on the last sweep cycle is kept
      bv_r <= cv[NUM_SLOTS];
      bp_r <= cp[NUM_SLOTS];
      bs_r <= cs[NUM_SLOTS];
    end
    if (st_r == pps_pkg::S_PICK) begin
      show_r <= (kind_r != pps_pkg::K_CREATE) || (32'(nnew_r) < NUM_SLOTS);
      unique case (kind_r)
        pps_pkg::K_TICK: begin
          rc_r <= pps_pkg::RC_OK;
          rs_r <= (do_q_r && bv_r) ? 4'(bs_r) : 4'(run_r);
        end
        pps_pkg::K_CREATE: begin
          if (32'(nnew_r) < NUM_SLOTS) begin
            rc_r <= pps_pkg::RC_OK;
            rs_r <= 4'(nnew_r);
          end else begin
            rc_r <= pps_pkg::RC_FULL;
            rs_r <= '0;
          end
        end
        pps_pkg::K_KILL, pps_pkg::K_SLEEP: begin
          rs_r <= slot_r;
          rc_r <= !exists ? pps_pkg::RC_NOENT :
                  (slot_r == 4'd0) ? pps_pkg::RC_KERNEL : pps_pkg::RC_OK;
        end
        pps_pkg::K_SETPRIO: begin
          rs_r <= slot_r;
          rc_r <= !exists ? pps_pkg::RC_NOENT :
                  (val_r > 32'(pps_pkg::PrioWorst)) ? pps_pkg::RC_BADPRIO : pps_pkg::RC_OK;
        end
        pps_pkg::K_QUERY: begin
          rs_r <= slot_r;
          rc_r <= in_rng ? pps_pkg::RC_OK : pps_pkg::RC_NOENT;
        end
        default: begin
          rs_r <= 4'(run_r);
          rc_r <= pps_pkg::RC_OK;
        end
      endcase
    end
  end

  `PPS_ASSERT_IMP(a_one_side, in_tready, !(st_r == pps_pkg::S_RESP), "busy while idle")
  `PPS_ASSERT_NXT(a_accept, in_tvalid && in_tready, st_r == pps_pkg::S_MUL, "accept lost")
  `PPS_ASSERT_IMP(a_run_rng, 1'b1, 32'(run_r) < NUM_SLOTS, "running slot out of range")
  `PPS_ASSERT_IMP(a_grant_ready, cmd.grant, bp_r <= 4'd15 && bv_r, "grant without winner")
endmodule
